>>> rtl/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, codes and controller/datapath structs of the hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = IDX_W + 1;
   localparam int KEY_WIDTH   = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int PRIME_W     = 10;
   localparam int MODE_W      = 2;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int COLL_W      = 10;
   localparam int HEAVY_W     = 16;
   localparam int SUM_W       = 32;
   localparam int MARK_W      = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   localparam int MOD_BITS    = 4;
   localparam int MOD_STEPS   = KEY_WIDTH / MOD_BITS;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);
   localparam int MOD_REM_W   = SIZE_W;

   localparam int HEAVY_LIMIT = 10;

   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1021);
   localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(1019);

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd3;

   localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED = 2'd1;
   localparam logic [MARK_W-1:0] MARK_GONE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_QUAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DBL_SUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DBL_ADD = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd2;

   typedef enum logic [1:0] {
      MOD_SEL_BASE,
      MOD_SEL_PRIME,
      MOD_SEL_STEP
   } mod_sel_type;

   typedef struct packed {
      logic                load;
      logic                clr_step;
      logic                mod_start;
      mod_sel_type         mod_sel;
      logic                probe_init;
      logic                advance;
      logic                ins_write;
      logic                del_write;
      logic                found_load;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } oaht_cmd_type;

   typedef struct packed {
      logic                clr_last;
      logic                full;
      logic                mod_done;
      logic                quad;
      logic [ACTION_W-1:0] action;
      logic [MARK_W-1:0]   mark;
      logic                key_match;
      logic                probe_last;
   } oaht_stat_type;

endpackage

>>> rtl/oaht_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht request and response interfaces
// Valid/ready channels carrying one transaction each.
// ----------------------------------------------------------------------------
interface oaht_req_if
   import oaht_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [KEY_WIDTH-1:0]  key;
   logic [DATA_WIDTH-1:0] payload;

   modport source (output valid, action, key, payload, input ready);
   modport sink   (input valid, action, key, payload, output ready);
endinterface

interface oaht_rsp_if
   import oaht_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [DATA_WIDTH-1:0] found_data;
   logic [COLL_W-1:0]     probe_collisions;
   logic [SIZE_W-1:0]     element_count;
   logic [COLL_W-1:0]     max_collisions;
   logic [HEAVY_W-1:0]    over_ten_count;
   logic [SUM_W-1:0]      collision_total;

   modport source (output valid, status, found_data, probe_collisions, element_count,
                   max_collisions, over_ten_count, collision_total, input ready);
   modport sink   (input valid, status, found_data, probe_collisions, element_count,
                   max_collisions, over_ten_count, collision_total, output ready);
endinterface

>>> rtl/oaht_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_mod_unit
// Restoring remainder unit, four dividend bits per cycle.
// ----------------------------------------------------------------------------
module oaht_mod_unit
   import oaht_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_WIDTH-1:0] dividend,
   input  logic [MOD_REM_W-1:0] divisor,
   output logic                 done,
   output logic [MOD_REM_W-1:0] remainder
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [MOD_CNT_W-1:0] cnt_ff;
   logic [KEY_WIDTH-1:0] dvd_ff;
   logic [MOD_REM_W-1:0] dvs_ff;
   logic [MOD_REM_W-1:0] rem_ff;
   logic [MOD_REM_W-1:0] rem_in;

   always_comb begin
      logic [MOD_REM_W:0] trial;
      rem_in = rem_ff;
      for (int j = 0; j < MOD_BITS; j++) begin
         trial = {rem_in, dvd_ff[KEY_WIDTH-1-j]};
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
         end
         rem_in = trial[MOD_REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << MOD_BITS;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/oaht_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_datapath
// Slot store, configuration, probe address generation and statistics.
// ----------------------------------------------------------------------------
module oaht_datapath
   import oaht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  oaht_cmd_type          cmd,
   output oaht_stat_type         stat,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [KEY_WIDTH-1:0]  req_key,
   input  logic [DATA_WIDTH-1:0] req_payload,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_found_data,
   output logic [COLL_W-1:0]     rsp_probe_collisions,
   output logic [SIZE_W-1:0]     rsp_element_count,
   output logic [COLL_W-1:0]     rsp_max_collisions,
   output logic [HEAVY_W-1:0]    rsp_over_ten_count,
   output logic [SUM_W-1:0]      rsp_collision_total
);

   logic [KEY_WIDTH-1:0]  key_ram  [TABLE_DEPTH];
   logic [DATA_WIDTH-1:0] data_ram [TABLE_DEPTH];
   logic [MARK_W-1:0]     mark_ram [TABLE_DEPTH];

   logic [SIZE_W-1:0]     size_ff;
   logic [PRIME_W-1:0]    prime_ff;
   logic [MODE_W-1:0]     mode_ff;

   logic [ACTION_W-1:0]   action_ff;
   logic [KEY_WIDTH-1:0]  key_ff;
   logic [DATA_WIDTH-1:0] payload_ff;

   logic [IDX_W-1:0]      clr_ff;
   logic [IDX_W-1:0]      base_ff;
   logic [PRIME_W-1:0]    rmod_ff;
   logic [IDX_W-1:0]      stepm_ff;
   mod_sel_type           sel_ff;

   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      inc_ff;
   logic [SIZE_W-1:0]     cnt_ff;
   logic [SIZE_W-1:0]     coll_ff;
   logic                  gone_ff;
   logic [IDX_W-1:0]      gone_at_ff;

   logic [KEY_WIDTH-1:0]  rd_key_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [MARK_W-1:0]     rd_mark_ff;

   logic [SIZE_W-1:0]     occ_ff;
   logic [COLL_W-1:0]     worst_ff;
   logic [HEAVY_W-1:0]    heavy_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [DATA_WIDTH-1:0] found_ff;
   logic [COLL_W-1:0]     coll_out_ff;

   logic [STATUS_W-1:0]   o_status_ff;
   logic [DATA_WIDTH-1:0] o_found_ff;
   logic [COLL_W-1:0]     o_coll_ff;
   logic [SIZE_W-1:0]     o_occ_ff;
   logic [COLL_W-1:0]     o_worst_ff;
   logic [HEAVY_W-1:0]    o_heavy_ff;
   logic [SUM_W-1:0]      o_sum_ff;

   logic [SIZE_W-1:0]     size_eff;
   logic [PRIME_W-1:0]    prime_eff;
   logic                  quad;
   logic [PRIME_W-1:0]    step_raw;
   logic [KEY_WIDTH-1:0]  mod_dvd;
   logic [MOD_REM_W-1:0]  mod_dvs;
   logic                  mod_done;
   logic [MOD_REM_W-1:0]  mod_rem;
   logic [IDX_W-1:0]      delta;
   logic [SIZE_W-1:0]     idx_sum;
   logic [IDX_W-1:0]      idx_in;
   logic [SIZE_W-1:0]     inc_a;
   logic [SIZE_W-1:0]     inc_b;
   logic [IDX_W-1:0]      inc_in;
   logic [IDX_W-1:0]      ins_pos;
   logic [SUM_W:0]        sum_ext;
   logic                  mark_we;
   logic [IDX_W-1:0]      mark_addr;
   logic [MARK_W-1:0]     mark_wdata;

   assign size_eff  = (size_ff == '0) ? SIZE_W'(1) :
                      (size_ff > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : size_ff;
   assign prime_eff = (prime_ff == '0) ? PRIME_W'(1) : prime_ff;
   assign quad      = !(mode_ff == MODE_DBL_SUB || mode_ff == MODE_DBL_ADD);
   assign step_raw  = (mode_ff == MODE_DBL_SUB) ? prime_eff - rmod_ff : rmod_ff + 1'b1;

   always_comb begin
      case (cmd.mod_sel)
         MOD_SEL_BASE: begin
            mod_dvd = key_ff;
            mod_dvs = size_eff;
         end
         MOD_SEL_PRIME: begin
            mod_dvd = key_ff;
            mod_dvs = MOD_REM_W'(prime_eff);
         end
         MOD_SEL_STEP: begin
            mod_dvd = KEY_WIDTH'(step_raw);
            mod_dvs = size_eff;
         end
         default: begin
            mod_dvd = key_ff;
            mod_dvs = size_eff;
         end
      endcase
   end

   oaht_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dvd),
      .divisor   (mod_dvs),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign delta   = quad ? inc_ff : stepm_ff;
   assign idx_sum = {1'b0, idx_ff} + {1'b0, delta};
   assign idx_in  = (idx_sum >= size_eff) ? IDX_W'(idx_sum - size_eff) : idx_sum[IDX_W-1:0];
   assign inc_a   = {1'b0, inc_ff} + SIZE_W'(2);
   assign inc_b   = (inc_a >= size_eff) ? inc_a - size_eff : inc_a;
   assign inc_in  = (inc_b >= size_eff) ? IDX_W'(inc_b - size_eff) : inc_b[IDX_W-1:0];
   assign ins_pos = gone_ff ? gone_at_ff : idx_ff;
   assign sum_ext = {1'b0, sum_ff} + (SUM_W + 1)'(coll_ff);

   always_comb begin
      mark_we    = 1'b0;
      mark_addr  = idx_ff;
      mark_wdata = MARK_FREE;
      if (cmd.clr_step) begin
         mark_we   = 1'b1;
         mark_addr = clr_ff;
      end else if (cmd.ins_write) begin
         mark_we    = 1'b1;
         mark_addr  = ins_pos;
         mark_wdata = MARK_USED;
      end else if (cmd.del_write) begin
         mark_we    = 1'b1;
         mark_wdata = MARK_GONE;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_ram[mark_addr] <= mark_wdata;
      end
      if (cmd.ins_write) begin
         key_ram[ins_pos]  <= key_ff;
         data_ram[ins_pos] <= payload_ff;
      end
      rd_mark_ff <= mark_ram[idx_ff];
      rd_key_ff  <= key_ram[idx_ff];
      rd_data_ff <= data_ram[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_RESET;
         prime_ff <= PRIME_RESET;
         mode_ff  <= MODE_QUAD;
         clr_ff   <= '0;
         occ_ff   <= '0;
         worst_ff <= '0;
         heavy_ff <= '0;
         sum_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SIZE:  size_ff  <= csr_write_data[SIZE_W-1:0];
               CSR_PRIME: prime_ff <= csr_write_data[PRIME_W-1:0];
               CSR_MODE:  mode_ff  <= csr_write_data[MODE_W-1:0];
               default:   ;
            endcase
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.ins_write) begin
            occ_ff <= occ_ff + 1'b1;
            if (coll_ff > SIZE_W'(worst_ff)) begin
               worst_ff <= (coll_ff > SIZE_W'({COLL_W{1'b1}})) ? '1 : coll_ff[COLL_W-1:0];
            end
            sum_ff <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (coll_ff > SIZE_W'(HEAVY_LIMIT) && heavy_ff != '1) begin
               heavy_ff <= heavy_ff + 1'b1;
            end
         end else if (cmd.del_write && occ_ff != '0) begin
            occ_ff <= occ_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_action;
         key_ff      <= req_key;
         payload_ff  <= req_payload;
         found_ff    <= '0;
         coll_out_ff <= '0;
      end
      if (cmd.mod_start) begin
         sel_ff <= cmd.mod_sel;
      end
      if (mod_done) begin
         case (sel_ff)
            MOD_SEL_BASE:  base_ff  <= mod_rem[IDX_W-1:0];
            MOD_SEL_PRIME: rmod_ff  <= mod_rem[PRIME_W-1:0];
            MOD_SEL_STEP:  stepm_ff <= mod_rem[IDX_W-1:0];
            default:       base_ff  <= mod_rem[IDX_W-1:0];
         endcase
      end
      if (cmd.probe_init) begin
         idx_ff  <= base_ff;
         inc_ff  <= (size_eff == SIZE_W'(1)) ? '0 : IDX_W'(1);
         cnt_ff  <= '0;
         coll_ff <= '0;
         gone_ff <= 1'b0;
      end else if (cmd.advance) begin
         idx_ff  <= idx_in;
         inc_ff  <= inc_in;
         cnt_ff  <= cnt_ff + 1'b1;
         coll_ff <= coll_ff + 1'b1;
         if (rd_mark_ff == MARK_GONE && !gone_ff) begin
            gone_ff    <= 1'b1;
            gone_at_ff <= idx_ff;
         end
      end
      if (cmd.ins_write) begin
         coll_out_ff <= coll_ff[COLL_W-1:0];
      end
      if (cmd.found_load) begin
         found_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         o_status_ff <= cmd.rsp_status;
         o_found_ff  <= found_ff;
         o_coll_ff   <= coll_out_ff;
         o_occ_ff    <= occ_ff;
         o_worst_ff  <= worst_ff;
         o_heavy_ff  <= heavy_ff;
         o_sum_ff    <= sum_ff;
      end
   end

   assign stat.clr_last   = (clr_ff == '1);
   assign stat.full       = (occ_ff >= size_eff);
   assign stat.mod_done   = mod_done;
   assign stat.quad       = quad;
   assign stat.action     = action_ff;
   assign stat.mark       = rd_mark_ff;
   assign stat.key_match  = (rd_key_ff == key_ff);
   assign stat.probe_last = (cnt_ff == size_eff - 1'b1);

   assign rsp_status           = o_status_ff;
   assign rsp_found_data       = o_found_ff;
   assign rsp_probe_collisions = o_coll_ff;
   assign rsp_element_count    = o_occ_ff;
   assign rsp_max_collisions   = o_worst_ff;
   assign rsp_over_ten_count   = o_heavy_ff;
   assign rsp_collision_total  = o_sum_ff;

endmodule

>>> rtl/oaht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer for clearing, hashing, probing and result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl
   import oaht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  oaht_stat_type stat,
   output oaht_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_BASE_GO,
      S_BASE_WAIT,
      S_PRIME_GO,
      S_PRIME_WAIT,
      S_STEP_GO,
      S_STEP_WAIT,
      S_INIT,
      S_READ,
      S_CHECK,
      S_LOAD,
      S_SEND
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [STATUS_W-1:0] code_ff;
   logic [STATUS_W-1:0] code_in;
   logic                is_insert;
   logic                is_lookup;
   logic                hit;
   logic                taken;

   assign is_insert = (stat.action == ACT_INSERT);
   assign is_lookup = (stat.action == ACT_SEARCH) || (stat.action == ACT_DELETE);
   assign hit       = (stat.mark == MARK_USED) && stat.key_match;
   assign taken     = (stat.mark == MARK_USED) || (stat.mark == MARK_GONE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BASE_GO;
            end
         end
         S_BASE_GO: begin
            if (!is_insert && !is_lookup) begin
               code_in  = STAT_DONE;
               state_in = S_LOAD;
            end else if (is_insert && stat.full) begin
               code_in  = STAT_FULL;
               state_in = S_LOAD;
            end else begin
               cmd.mod_start = 1'b1;
               cmd.mod_sel   = MOD_SEL_BASE;
               state_in      = S_BASE_WAIT;
            end
         end
         S_BASE_WAIT: begin
            cmd.mod_sel = MOD_SEL_BASE;
            if (stat.mod_done) state_in = stat.quad ? S_INIT : S_PRIME_GO;
         end
         S_PRIME_GO: begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = MOD_SEL_PRIME;
            state_in      = S_PRIME_WAIT;
         end
         S_PRIME_WAIT: begin
            cmd.mod_sel = MOD_SEL_PRIME;
            if (stat.mod_done) state_in = S_STEP_GO;
         end
         S_STEP_GO: begin
            cmd.mod_start = 1'b1;
            cmd.mod_sel   = MOD_SEL_STEP;
            state_in      = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            cmd.mod_sel = MOD_SEL_STEP;
            if (stat.mod_done) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.probe_init = 1'b1;
            state_in       = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               if (is_insert) begin
                  code_in = STAT_DUP;
               end else begin
                  code_in        = STAT_DONE;
                  cmd.found_load = (stat.action == ACT_SEARCH);
                  cmd.del_write  = (stat.action == ACT_DELETE);
               end
               state_in = S_LOAD;
            end else if (taken) begin
               if (stat.probe_last) begin
                  code_in  = is_insert ? STAT_FULL : STAT_MISS;
                  state_in = S_LOAD;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end else begin
               if (is_insert) begin
                  cmd.ins_write = 1'b1;
                  code_in       = STAT_DONE;
               end else begin
                  code_in = STAT_MISS;
               end
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = code_ff;
            state_in       = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= STAT_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);

endmodule

>>> rtl/open_addressing_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top
// Open-addressing key/data table with quadratic or double-hash probing.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per action (insert, search, delete) with
//   key and payload; rsp_chan returns exactly one result transaction for each,
//   with status, found data and the insert statistics.
//   csr_write_en/csr_index/csr_write_data set table size, step prime and probe
//   mode; write them only while no transaction is in flight.
//   After reset the marks of all 1024 slots are swept to free, one slot per
//   cycle; req_chan.ready stays low meanwhile.
//   One transaction is handled at a time. Each starts with the key remainder
//   modulo the table size; the double-hash modes then also take the key
//   remainder modulo the step prime and the remainder of the step, all in the
//   shared remainder unit. Each probed slot then takes one slot-store read,
//   and rsp_chan.valid rises once the probe ends. An action rejected up front
//   (unknown code or full table) skips the remainders and the probes.
//   The next transaction is accepted once the result is taken and the
//   controller has returned to idle; the result is held in an output
//   register until rsp_chan.ready is seen; a stalled receiver simply holds
//   off the next transaction.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top
   import oaht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   oaht_req_if.sink              req_chan,
   oaht_rsp_if.source            rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   oaht_cmd_type  cmd;
   oaht_stat_type stat;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   oaht_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_action           (req_chan.action),
      .req_key              (req_chan.key),
      .req_payload          (req_chan.payload),
      .rsp_status           (rsp_chan.status),
      .rsp_found_data       (rsp_chan.found_data),
      .rsp_probe_collisions (rsp_chan.probe_collisions),
      .rsp_element_count    (rsp_chan.element_count),
      .rsp_max_collisions   (rsp_chan.max_collisions),
      .rsp_over_ten_count   (rsp_chan.over_ten_count),
      .rsp_collision_total  (rsp_chan.collision_total)
   );

endmodule
